>>> rtl/core/rrvd_pkg.sv
package rrvd_pkg;

  // Pipeline depths of the two iterative units.
  localparam int SqrtSteps = 23;
  localparam int DivSteps  = 17;

  // Configuration register indexes.
  localparam logic [2:0] RegCenterX  = 3'd0;
  localparam logic [2:0] RegCenterY  = 3'd1;
  localparam logic [2:0] RegRadius   = 3'd2;
  localparam logic [2:0] RegWaves    = 3'd3;
  localparam logic [2:0] RegAmp      = 3'd4;
  localparam logic [2:0] RegAmpRate  = 3'd5;

  // 0.1 / (2*pi) in Q0.24, used to turn the distance into a phase offset.
  localparam logic [18:0] KDphase = 19'd267018;

  // Odd sine polynomial coefficients, Q1.30.
  localparam logic [30:0] SA1 = 31'd1686629713;
  localparam logic [30:0] SA3 = 31'd693598668;
  localparam logic [30:0] SA5 = 31'd85569306;
  localparam logic [30:0] SA7 = 31'd5026995;
  localparam logic [30:0] SA9 = 31'd172272;

  // Vertex data that rides along the pipeline.
  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [23:0] x;
    logic [23:0] y;
    logic [23:0] z;
    logic [16:0] t;
    logic        hit;
  } vtx_t;

  // Sideband carried through the divider.
  typedef struct packed {
    vtx_t        v;
    logic [15:0] phase;
  } div_side_t;

endpackage

>>> rtl/core/rrvd_isqrt.sv
module rrvd_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [45:0]          radicand,
  input  rrvd_pkg::vtx_t       in_side,
  output logic                 out_valid,
  output logic [22:0]          root,
  output rrvd_pkg::vtx_t       out_side
);

  // One result bit per stage, digit-by-digit square root.
  logic                 vld [rrvd_pkg::SqrtSteps];
  logic [22:0]          rt  [rrvd_pkg::SqrtSteps];
  logic [24:0]          rm  [rrvd_pkg::SqrtSteps];
  logic [45:0]          nsh [rrvd_pkg::SqrtSteps];
  rrvd_pkg::vtx_t       sd  [rrvd_pkg::SqrtSteps];

  for (genvar k = 0; k < rrvd_pkg::SqrtSteps; k++) begin : g_step
    logic           vld_i;
    logic [22:0]    rt_i;
    logic [24:0]    rm_i;
    logic [45:0]    nsh_i;
    rrvd_pkg::vtx_t sd_i;
    logic [25:0]    remx;
    logic [25:0]    trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign vld_i = in_valid;
      assign rt_i  = '0;
      assign rm_i  = '0;
      assign nsh_i = radicand;
      assign sd_i  = in_side;
    end else begin : g_next
      assign vld_i = vld[k-1];
      assign rt_i  = rt[k-1];
      assign rm_i  = rm[k-1];
      assign nsh_i = nsh[k-1];
      assign sd_i  = sd[k-1];
    end

    assign remx  = {rm_i[23:0], nsh_i[45:44]};
    assign trial = {2'b00, rt_i[21:0], 2'b01};
    assign ge    = (remx >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_i;
      end
      rt[k]  <= {rt_i[21:0], ge};
      rm[k]  <= ge ? 25'(remx - trial) : remx[24:0];
      nsh[k] <= {nsh_i[43:0], 2'b00};
      sd[k]  <= sd_i;
    end
  end

  assign out_valid = vld[rrvd_pkg::SqrtSteps-1];
  assign root      = rt[rrvd_pkg::SqrtSteps-1];
  assign out_side  = sd[rrvd_pkg::SqrtSteps-1];

endmodule

>>> rtl/core/rrvd_div.sv
module rrvd_div (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [45:0]          dividend,
  input  logic [45:0]          divisor,
  input  rrvd_pkg::div_side_t  in_side,
  output logic                 out_valid,
  output logic [16:0]          quot,
  output rrvd_pkg::div_side_t  out_side
);

  // Restoring division of (dividend << 16) by divisor, one quotient bit
  // per stage. The divisor comes from configuration; the user must hold it
  // while words are in flight, and the block itself does not enforce this.
  logic                  vld [rrvd_pkg::DivSteps];
  logic [16:0]           q   [rrvd_pkg::DivSteps];
  logic [45:0]           rm  [rrvd_pkg::DivSteps];
  rrvd_pkg::div_side_t   sd  [rrvd_pkg::DivSteps];

  for (genvar k = 0; k < rrvd_pkg::DivSteps; k++) begin : g_step
    logic                vld_i;
    logic [16:0]         q_i;
    logic [46:0]         remx;
    rrvd_pkg::div_side_t sd_i;
    logic                ge;

    if (k == 0) begin : g_first
      assign vld_i = in_valid;
      assign q_i   = '0;
      assign remx  = {1'b0, dividend};
      assign sd_i  = in_side;
    end else begin : g_next
      assign vld_i = vld[k-1];
      assign q_i   = q[k-1];
      assign remx  = {rm[k-1], 1'b0};
      assign sd_i  = sd[k-1];
    end

    assign ge = (remx >= {1'b0, divisor});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld_i;
      end
      q[k]  <= {q_i[15:0], ge};
      rm[k] <= ge ? 46'(remx - {1'b0, divisor}) : remx[45:0];
      sd[k] <= sd_i;
    end
  end

  assign out_valid = vld[rrvd_pkg::DivSteps-1];
  assign quot      = q[rrvd_pkg::DivSteps-1];
  assign out_side  = sd[rrvd_pkg::DivSteps-1];

endmodule

>>> rtl/core/radial_ripple_vertex_displace_top.sv
// Radial ripple vertex displacement. Each word is one grid vertex; a vertex
// within ripple_radius of the center gets its z pushed by a sine ripple that
// fades as (d/radius)^2, and every other vertex passes through. The block is
// a fixed pipeline with no back-pressure: busy is always low, so a vertex
// may be started on every clock cycle, and each result appears on the out
// ports with done high for exactly one cycle. Results leave in the order
// the vertices came in. The receiver cannot stall the block and must take
// each result in the cycle it is shown. The pipeline runs through the
// 23-stage square root, the 17-stage divider for the fade factor and the
// chain of multipliers of the sine polynomial. Configuration writes take
// effect at once and must only be made while no vertex is in flight.
module radial_ripple_vertex_displace_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  grid_col,
  input  logic [7:0]  grid_row,
  input  logic [23:0] vert_x,
  input  logic [23:0] vert_y,
  input  logic [23:0] vert_z,
  input  logic [16:0] frame_time,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  output logic        done,
  output logic [7:0]  out_col,
  output logic [7:0]  out_row,
  output logic [23:0] out_x,
  output logic [23:0] out_y,
  output logic [23:0] out_z,
  output logic        inside_radius
);

  // Configuration registers.
  logic [23:0] center_x;
  logic [23:0] center_y;
  logic [22:0] ripple_radius;
  logic [7:0]  wave_count;
  logic [23:0] amplitude;
  logic [16:0] amplitude_rate;
  logic [45:0] radius_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      ripple_radius  <= 23'd256;
      wave_count     <= '0;
      amplitude      <= '0;
      amplitude_rate <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        rrvd_pkg::RegCenterX: center_x       <= cfg_data;
        rrvd_pkg::RegCenterY: center_y       <= cfg_data;
        rrvd_pkg::RegRadius:  ripple_radius  <= cfg_data[22:0];
        rrvd_pkg::RegWaves:   wave_count     <= cfg_data[7:0];
        rrvd_pkg::RegAmp:     amplitude      <= cfg_data;
        rrvd_pkg::RegAmpRate: amplitude_rate <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // The squared radius is registered from the radius register in the next cycle,
  // which is well before the first started vertex reaches the compare.
  always_ff @(posedge clk) begin
    radius_sq <= ripple_radius * ripple_radius;
  end

  assign busy = 1'b0;

  // Stage A: absolute coordinate differences to the ripple center.
  logic           a_vld;
  rrvd_pkg::vtx_t a_v;
  logic [24:0]    a_adx;
  logic [24:0]    a_ady;
  logic [24:0]    dx;
  logic [24:0]    dy;

  assign dx = {center_x[23], center_x} - {vert_x[23], vert_x};
  assign dy = {center_y[23], center_y} - {vert_y[23], vert_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= start;
    end
    a_v.col    <= grid_col;
    a_v.row    <= grid_row;
    a_v.x      <= vert_x;
    a_v.y      <= vert_y;
    a_v.z      <= vert_z;
    a_v.t      <= frame_time;
    a_v.hit    <= 1'b0;
    a_adx      <= dx[24] ? 25'(~dx + 25'd1) : dx;
    a_ady      <= dy[24] ? 25'(~dy + 25'd1) : dy;
  end

  // Stage B: the two squares.
  logic           b_vld;
  rrvd_pkg::vtx_t b_v;
  logic [49:0]    b_sqx;
  logic [49:0]    b_sqy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
    b_v   <= a_v;
    b_sqx <= a_adx * a_adx;
    b_sqy <= a_ady * a_ady;
  end

  // Stage C: squared distance and the inside test. Only an inside vertex
  // uses the root, and its squared distance is below 2^46.
  logic           c_vld;
  rrvd_pkg::vtx_t c_v;
  rrvd_pkg::vtx_t c_v_next;
  logic [45:0]    c_r2;
  logic [50:0]    r2_sum;

  assign r2_sum = {1'b0, b_sqx} + {1'b0, b_sqy};

  always_comb begin
    c_v_next     = b_v;
    c_v_next.hit = (r2_sum < {5'd0, radius_sq});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
    c_v        <= c_v_next;
    c_r2       <= r2_sum[45:0];
  end

  // Integer square root of the distance.
  logic           s_vld;
  logic [22:0]    s_root;
  rrvd_pkg::vtx_t s_v;

  rrvd_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_vld),
    .radicand  (c_r2),
    .in_side   (c_v),
    .out_valid (s_vld),
    .root      (s_root),
    .out_side  (s_v)
  );

  // Stage E: distance inside the rim.
  logic           e_vld;
  rrvd_pkg::vtx_t e_v;
  logic [22:0]    e_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_vld <= 1'b0;
    end else begin
      e_vld <= s_vld;
    end
    e_v <= s_v;
    e_d <= 23'(ripple_radius - s_root);
  end

  // Stage F: d squared, and the two parts of the phase.
  logic           f_vld;
  rrvd_pkg::vtx_t f_v;
  logic [45:0]    f_d2;
  logic [15:0]    f_dk;
  logic [15:0]    f_tw;
  logic [41:0]    dk_prod;
  logic [24:0]    tw_prod;

  assign dk_prod = e_d * rrvd_pkg::KDphase;
  assign tw_prod = e_v.t * wave_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= e_vld;
    end
    f_v  <= e_v;
    f_d2 <= e_d * e_d;
    f_dk <= 16'((dk_prod + 42'h8000) >> 16);
    f_tw <= tw_prod[15:0];
  end

  // Fade factor (d/radius)^2 in Q1.16.
  rrvd_pkg::div_side_t f_side;
  rrvd_pkg::div_side_t q_side;
  logic                q_vld;
  logic [16:0]         q_rate;

  assign f_side.v     = f_v;
  assign f_side.phase = 16'(f_tw + f_dk);

  rrvd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_vld),
    .dividend  (f_d2),
    .divisor   (radius_sq),
    .in_side   (f_side),
    .out_valid (q_vld),
    .quot      (q_rate),
    .out_side  (q_side)
  );

  // Stage H: quarter-wave fold of the phase, and the amplitude scale.
  logic           h_vld;
  rrvd_pkg::vtx_t h_v;
  logic [14:0]    h_x;
  logic           h_neg;
  logic [16:0]    h_scale;
  logic [33:0]    scale_prod;

  assign scale_prod = amplitude_rate * q_rate;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_vld <= 1'b0;
    end else begin
      h_vld <= q_vld;
    end
    h_v     <= q_side.v;
    h_x     <= q_side.phase[14] ? 15'(15'h4000 - {1'b0, q_side.phase[13:0]})
                                : {1'b0, q_side.phase[13:0]};
    h_neg   <= q_side.phase[15];
    h_scale <= 17'((scale_prod + 34'h8000) >> 16);
  end

  // Stage I: u^2 in Q1.30, which is x*x*4 since u is x shifted by 14.
  logic           i_vld;
  rrvd_pkg::vtx_t i_v;
  logic [14:0]    i_x;
  logic           i_neg;
  logic [16:0]    i_scale;
  logic [30:0]    i_u2;
  logic [29:0]    x_sq;

  assign x_sq = h_x * h_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      i_vld <= 1'b0;
    end else begin
      i_vld <= h_vld;
    end
    i_v     <= h_v;
    i_x     <= h_x;
    i_neg   <= h_neg;
    i_scale <= h_scale;
    i_u2    <= {x_sq[28:0], 2'b00};
  end

  // Stages J through M: Horner steps of the polynomial, one product each.
  logic           j_vld, k_vld, l_vld, m_vld;
  rrvd_pkg::vtx_t j_v, k_v, l_v, m_v;
  logic [14:0]    j_x, k_x, l_x, m_x;
  logic           j_neg, k_neg, l_neg, m_neg;
  logic [16:0]    j_scale, k_scale, l_scale, m_scale;
  logic [30:0]    j_u2, k_u2, l_u2;
  logic [30:0]    j_s, k_s, l_s, m_s;
  logic [61:0]    j_prod, k_prod, l_prod, m_prod;

  assign j_prod = rrvd_pkg::SA9 * i_u2;
  assign k_prod = j_s * j_u2;
  assign l_prod = k_s * k_u2;
  assign m_prod = l_s * l_u2;

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
      k_vld <= 1'b0;
      l_vld <= 1'b0;
      m_vld <= 1'b0;
    end else begin
      j_vld <= i_vld;
      k_vld <= j_vld;
      l_vld <= k_vld;
      m_vld <= l_vld;
    end
    j_v <= i_v;  j_x <= i_x;  j_neg <= i_neg;  j_scale <= i_scale;  j_u2 <= i_u2;
    k_v <= j_v;  k_x <= j_x;  k_neg <= j_neg;  k_scale <= j_scale;  k_u2 <= j_u2;
    l_v <= k_v;  l_x <= k_x;  l_neg <= k_neg;  l_scale <= k_scale;  l_u2 <= k_u2;
    m_v <= l_v;  m_x <= l_x;  m_neg <= l_neg;  m_scale <= l_scale;
    j_s <= 31'(rrvd_pkg::SA7 - 31'(j_prod >> 30));
    k_s <= 31'(rrvd_pkg::SA5 - 31'(k_prod >> 30));
    l_s <= 31'(rrvd_pkg::SA3 - 31'(l_prod >> 30));
    m_s <= 31'(rrvd_pkg::SA1 - 31'(m_prod >> 30));
  end

  // Stage N: final multiply by u, which reduces to s*x >> 14.
  logic           n_vld;
  rrvd_pkg::vtx_t n_v;
  logic           n_neg;
  logic [16:0]    n_scale;
  logic [31:0]    n_m;
  logic [45:0]    sx_prod;

  assign sx_prod = m_s * m_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      n_vld <= 1'b0;
    end else begin
      n_vld <= m_vld;
    end
    n_v     <= m_v;
    n_neg   <= m_neg;
    n_scale <= m_scale;
    n_m     <= sx_prod[45:14];
  end

  // Stage O: round the sine to Q1.16 and cap it at one.
  logic           o_vld;
  rrvd_pkg::vtx_t o_v;
  logic           o_neg;
  logic [16:0]    o_scale;
  logic [16:0]    o_smag;
  logic [32:0]    m_round;
  logic [18:0]    m_q16;

  assign m_round = {1'b0, n_m} + 33'h2000;
  assign m_q16   = m_round[32:14];

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else begin
      o_vld <= n_vld;
    end
    o_v     <= n_v;
    o_neg   <= n_neg;
    o_scale <= n_scale;
    o_smag  <= (m_q16 > 19'd65536) ? 17'd65536 : m_q16[16:0];
  end

  // Stage P: sine magnitude times amplitude magnitude.
  logic           p_vld;
  rrvd_pkg::vtx_t p_v;
  logic           p_neg;
  logic [16:0]    p_scale;
  logic [40:0]    p_prod;
  logic [23:0]    amp_mag;

  assign amp_mag = amplitude[23] ? 24'(~amplitude + 24'd1) : amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= o_vld;
    end
    p_v     <= o_v;
    p_neg   <= o_neg ^ amplitude[23];
    p_scale <= o_scale;
    p_prod  <= o_smag * amp_mag;
  end

  // Stage Q: apply the scale and round the displacement half away from zero.
  logic           q2_vld;
  rrvd_pkg::vtx_t q2_v;
  logic           q2_neg;
  logic [25:0]    q2_mag;
  logic [57:0]    mag_prod;
  logic [57:0]    mag_round;

  assign mag_prod  = p_prod * p_scale;
  assign mag_round = mag_prod + 58'h80000000;

  always_ff @(posedge clk) begin
    if (rst) begin
      q2_vld <= 1'b0;
    end else begin
      q2_vld <= p_vld;
    end
    q2_v   <= p_v;
    q2_neg <= p_neg;
    q2_mag <= mag_round[57:32];
  end

  // Stage R: add to z with saturation, into the output register.
  logic [26:0] z_wide;
  logic [26:0] z_sum;
  logic [23:0] z_sat;

  assign z_wide = {{3{q2_v.z[23]}}, q2_v.z};
  assign z_sum  = q2_neg ? 27'(z_wide - {1'b0, q2_mag}) : 27'(z_wide + {1'b0, q2_mag});

  always_comb begin
    if (!z_sum[26] && (z_sum[25:23] != 3'b000)) begin
      z_sat = 24'h7FFFFF;
    end else if (z_sum[26] && (z_sum[25:23] != 3'b111)) begin
      z_sat = 24'h800000;
    end else begin
      z_sat = z_sum[23:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= q2_vld;
    end
    out_col       <= q2_v.col;
    out_row       <= q2_v.row;
    out_x         <= q2_v.x;
    out_y         <= q2_v.y;
    out_z         <= q2_v.hit ? z_sat : q2_v.z;
    inside_radius <= q2_v.hit;
  end

endmodule
